FILE: rtl/core/qse_pkg.sv
// Shared types and constants of the quantization squared-error core.
`default_nettype none

package qse_pkg;

    // Number of levels that take part in the nearest-level choice (2..8).
    localparam int LEVELS    = 8;
    // Number of level registers on the configuration port.
    localparam int NUM_REGS  = 8;
    localparam int PIX_W     = 8;
    localparam int LVL_IDX_W = $clog2(NUM_REGS);
    localparam int SQ_W      = 2 * PIX_W;
    localparam int ACC_W     = 48;
    localparam int CFG_IDX_W = 4;

    typedef logic [PIX_W-1:0]               t_pixel;
    typedef logic [LVL_IDX_W-1:0]           t_lvl_idx;
    typedef logic [ACC_W-1:0]               t_acc;
    typedef logic [CFG_IDX_W-1:0]           t_cfg_idx;
    typedef logic [NUM_REGS-1:0][PIX_W-1:0] t_levels;

    // Register map: level_0 .. level_7 sit at indexes 0 .. NUM_REGS-1.
    localparam t_cfg_idx REG_LEVEL_LAST = CFG_IDX_W'(NUM_REGS - 1);

    localparam t_acc ACC_MAX = '1;

    // Reset values of the levels, level_0 in the low byte.
    localparam t_levels LEVEL_RESET = {
        8'd224, 8'd192, 8'd160, 8'd128, 8'd96, 8'd64, 8'd32, 8'd0
    };

    // Control from the pipeline to the accumulator.
    typedef struct packed {
        logic en;    // a pixel moves into the result register
        logic last;  // that pixel closes the image
    } t_acc_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/qse_intf.sv
// Channel interfaces: pixel input, result output and configuration write.
`default_nettype none

interface qse_pix_if;
    import qse_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel pixel;
    logic   last_pixel;
    modport source (output valid, pixel, last_pixel, input ready);
    modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface qse_res_if;
    import qse_pkg::*;
    logic     valid;
    logic     ready;
    t_pixel   quantized;
    t_lvl_idx level_index;
    t_acc     error_sum;
    logic     image_done;
    modport source (output valid, quantized, level_index, error_sum, image_done, input ready);
    modport sink   (input valid, quantized, level_index, error_sum, image_done, output ready);
endinterface

interface qse_cfg_if;
    import qse_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_pixel   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/qse_cfg_regs.sv
// Level register file written through the configuration channel.
`default_nettype none

module qse_cfg_regs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    qse_cfg_if.sink              i_cfg,
    output qse_pkg::t_levels     o_levels
);
    import qse_pkg::*;

    t_levels r_levels;

    // Always ready; writes beyond the register map are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVEL_RESET;
        end else if (i_cfg.valid && (i_cfg.index <= REG_LEVEL_LAST)) begin
            r_levels[i_cfg.index[LVL_IDX_W-1:0]] <= i_cfg.data;
        end
    end

    assign o_levels = r_levels;

endmodule

`default_nettype wire

FILE: rtl/core/qse_nearest.sv
// Nearest-level selection: distance to each level, ties to the higher index.
`default_nettype none

module qse_nearest (
    input  wire qse_pkg::t_pixel   i_pixel,
    input  wire qse_pkg::t_levels  i_levels,
    output qse_pkg::t_lvl_idx      o_index,
    output qse_pkg::t_pixel        o_level,
    output qse_pkg::t_pixel        o_dist
);
    import qse_pkg::*;

    t_pixel   lvl_diff [LEVELS];
    t_lvl_idx best_idx;
    t_pixel   best_dist;

    // Independent absolute differences, one per level.
    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            lvl_diff[k] = (i_pixel >= i_levels[k]) ? (i_pixel - i_levels[k])
                                                   : (i_levels[k] - i_pixel);
        end
    end

    // Running minimum; <= lets a later equal distance take over.
    always_comb begin
        best_idx  = '0;
        best_dist = lvl_diff[0];
        for (int k = 1; k < LEVELS; k++) begin
            if (lvl_diff[k] <= best_dist) begin
                best_idx  = LVL_IDX_W'(k);
                best_dist = lvl_diff[k];
            end
        end
    end

    assign o_index = best_idx;
    assign o_level = i_levels[best_idx];
    assign o_dist  = best_dist;

endmodule

`default_nettype wire

FILE: rtl/core/qse_accum.sv
// Squared error and saturating 48-bit error accumulator.
`default_nettype none

module qse_accum (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qse_pkg::t_acc_ctl i_ctl,
    input  wire qse_pkg::t_pixel   i_dist,
    output qse_pkg::t_acc          o_sum
);
    import qse_pkg::*;

    t_acc             r_acc;
    t_acc             n_acc;
    logic [SQ_W-1:0]  sq;
    logic [ACC_W:0]   wide_sum;

    assign sq       = i_dist * i_dist;
    assign wide_sum = {1'b0, r_acc} + (ACC_W + 1)'(sq);
    // Carry out of the top bit means the sum passed the maximum.
    assign o_sum    = wide_sum[ACC_W] ? ACC_MAX : wide_sum[ACC_W-1:0];
    assign n_acc    = i_ctl.last ? '0 : o_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && i_ctl.last |=> r_acc == '0)
        else $error("accumulator not cleared after last pixel");

    a_tracks_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && !i_ctl.last |=> r_acc == $past(o_sum))
        else $error("accumulator does not hold the reported sum");

    a_saturated_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && !i_ctl.last && r_acc == ACC_MAX |=> r_acc == ACC_MAX)
        else $error("saturated accumulator moved");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.en |=> $stable(r_acc))
        else $error("accumulator changed without a pixel");

endmodule

`default_nettype wire

FILE: rtl/core/quantization_squared_error_core.sv
// Top level of the nearest-level quantizer with squared-error accumulation.
`default_nettype none

// Each grey pixel word on i_pix is matched against the first LEVELS of eight
// configurable levels; the nearest level wins, and on equal distance the
// higher index wins. The result word gives the chosen level value, its index,
// the running 48-bit sum of squared errors including this pixel (saturating
// at 2^48-1) and image_done, a copy of last_pixel. After a pixel marked last
// the sum restarts at zero for the next image. Throughput is one pixel per
// clock while o_res takes every word. A pixel accepted on i_pix sits in the
// input register and loads into the result register when that register is
// free or being taken; the level compares, the 8x8 square and the 48-bit
// saturating add sit between the two registers. The accumulator loop closes
// around that single add, which sets the one-per-cycle figure. Input stays
// ready while a finished result waits only as long as the input register is
// empty. Levels are written on i_cfg (index 0..7, data 8 bits, always
// ready); writes to indexes beyond 7 are ignored. Write levels only while no
// pixel is in flight. Levels reset to 0, 32, 64 ... 224.

module quantization_squared_error_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qse_pix_if.sink   i_pix,
    qse_res_if.source o_res,
    qse_cfg_if.sink   i_cfg
);
    import qse_pkg::*;

    // Input register
    logic     r_s1_valid;
    t_pixel   r_s1_pixel;
    logic     r_s1_last;

    // Result register
    logic     r_out_valid;
    t_pixel   r_out_quantized;
    t_lvl_idx r_out_index;
    t_acc     r_out_sum;
    logic     r_out_done;

    t_levels  levels;
    t_lvl_idx sel_index;
    t_pixel   sel_level;
    t_pixel   sel_dist;
    t_acc     sum;
    t_acc_ctl acc_ctl;
    logic     adv_out;   // input register moves into the result register
    logic     in_take;   // pixel word accepted

    assign adv_out     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || adv_out;
    assign in_take     = i_pix.valid && i_pix.ready;

    assign acc_ctl.en   = adv_out;
    assign acc_ctl.last = r_s1_last;

    qse_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_levels (levels)
    );

    qse_nearest u_nearest (
        .i_pixel  (r_s1_pixel),
        .i_levels (levels),
        .o_index  (sel_index),
        .o_level  (sel_level),
        .o_dist   (sel_dist)
    );

    qse_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_dist  (sel_dist),
        .o_sum   (sum)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_pixel <= i_pix.pixel;
            r_s1_last  <= i_pix.last_pixel;
        end
        if (adv_out) begin
            r_out_quantized <= sel_level;
            r_out_index     <= sel_index;
            r_out_sum       <= sum;
            r_out_done      <= r_s1_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.quantized   = r_out_quantized;
    assign o_res.level_index = r_out_index;
    assign o_res.error_sum   = r_out_sum;
    assign o_res.image_done  = r_out_done;

endmodule

`default_nettype wire

FILE: test/tb_quantization_squared_error_core.sv
// Self-checking testbench of the nearest-level quantizer with squared-error sum.
`timescale 1ns / 100ps

// Stimulus walks a directed table first, then eight random phases. Each phase
// reloads all eight levels, sometimes pokes the unused register indexes, and
// streams pixels in images of random length. Every accepted pixel runs through
// a local predictor. Each result word on o_res is compared, field by field,
// against the oldest prediction.
module tb_quantization_squared_error_core;
    import qse_pkg::*;

    localparam int       ITEMS_PER_PHASE = 250;
    localparam int       PHASES          = 8;
    localparam int       HOLD_PHASE      = 1;     // phase with the long result hold-off
    localparam int       HOLD_CYCLES     = 300;
    localparam int       QUIET_LIMIT     = 1000;  // cycles with no word moving anywhere
    localparam int       SETTLE_CYCLES   = 8;     // pipeline is two deep, plus margin
    localparam int       PRINT_LIMIT     = 50;
    localparam int       DIRECTED_COUNT  = 18;

    localparam t_cfg_idx REG_LEVEL_0  = '0;
    localparam t_cfg_idx REG_BEYOND   = REG_LEVEL_LAST + t_cfg_idx'(1);  // first past the list
    localparam t_cfg_idx REG_TOP      = '1;
    localparam t_levels  LV_NONE      = '0;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_LEVELS, ROW_STRAY} t_row_kind;
    typedef enum logic [2:0] {
        LV_SPREAD, LV_SCATTER, LV_ALL_LOW, LV_ALL_HIGH, LV_ALTERNATE, LV_PAIRS
    } t_level_style;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_DUTY} t_stall_mode;

    // One result word as it leaves the block.
    typedef struct packed {
        t_pixel   quantized;
        t_lvl_idx level_index;
        t_acc     error_sum;
        logic     image_done;
    } t_qse_word;

    // Directed stimulus row. A pixel row with typed set carries its own expected
    // word; otherwise the predictor supplies it. ROW_STRAY writes its pixel
    // field as data to indexes past the level list.
    typedef struct packed {
        t_row_kind kind;
        t_pixel    pixel;
        logic      last;
        logic      typed;
        t_pixel    quantized;
        t_lvl_idx  level_index;
        t_acc      error_sum;
        t_levels   levels;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qse_pix_if pix_bus ();
    qse_res_if res_bus ();
    qse_cfg_if cfg_bus ();

    quantization_squared_error_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: its own copy of the levels and the running sum.
    t_levels     level_set;
    t_acc        sse_acc;

    t_row        offered_rows [$];    // pixels driven, in order, not yet accepted
    t_qse_word   predicted_words [$];  // accepted pixels still owed a result
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned mismatch_count;
    bit          hold_request;
    int          image_left;

    // Reset levels, then a few hand-checked words. Ties go to the higher
    // index; with all levels equal the top index always wins.
    t_row directed_rows [DIRECTED_COUNT] = '{
        '{ROW_PIXEL,  8'd0,   1'b0, 1'b1, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd255, 1'b1, 1'b1, 8'd224, 3'd7, 48'd961,   LV_NONE},
        '{ROW_PIXEL,  8'd16,  1'b0, 1'b1, 8'd32,  3'd1, 48'd256,   LV_NONE},  // tie 0/32
        '{ROW_PIXEL,  8'd48,  1'b0, 1'b1, 8'd64,  3'd2, 48'd512,   LV_NONE},  // tie 32/64
        '{ROW_PIXEL,  8'd240, 1'b1, 1'b1, 8'd224, 3'd7, 48'd768,   LV_NONE},
        '{ROW_PIXEL,  8'd85,  1'b0, 1'b1, 8'd96,  3'd3, 48'd121,   LV_NONE},
        '{ROW_PIXEL,  8'd170, 1'b1, 1'b1, 8'd160, 3'd5, 48'd221,   LV_NONE},
        '{ROW_LEVELS, 8'd0,   1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     {8{8'd128}}},
        '{ROW_PIXEL,  8'd0,   1'b0, 1'b1, 8'd128, 3'd7, 48'd16384, LV_NONE},
        '{ROW_PIXEL,  8'd255, 1'b1, 1'b1, 8'd128, 3'd7, 48'd32513, LV_NONE},
        // unordered levels, with level_0 at the top of the range
        '{ROW_LEVELS, 8'd0,   1'b0, 1'b0, 8'd0,   3'd0, 48'd0,
          {8'd5, 8'd250, 8'd100, 8'd150, 8'd50, 8'd200, 8'd0, 8'd255}},
        '{ROW_STRAY,  8'd0,   1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd0,   1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd255, 1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd125, 1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd175, 1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd3,   1'b0, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE},
        '{ROW_PIXEL,  8'd252, 1'b1, 1'b0, 8'd0,   3'd0, 48'd0,     LV_NONE}
    };

    t_level_style phase_style [PHASES] = '{
        LV_SPREAD, LV_SCATTER, LV_ALL_LOW, LV_ALL_HIGH,
        LV_ALTERNATE, LV_PAIRS, LV_SCATTER, LV_SPREAD
    };

    // Nearest level among the first LEVELS, higher index on a tie; squared
    // distance added into the saturating sum, which clears after a last pixel.
    function automatic t_qse_word quantize_pixel(t_pixel px, logic last);
        t_qse_word word;
        t_pixel    diff;
        t_pixel    best_dist;
        t_acc      sq;
        t_acc      sum;
        int        best;
        best      = 0;
        best_dist = (px >= level_set[0]) ? px - level_set[0] : level_set[0] - px;
        for (int k = 1; k < LEVELS; k++) begin
            diff = (px >= level_set[k]) ? px - level_set[k] : level_set[k] - px;
            if (diff <= best_dist) begin
                best_dist = diff;
                best      = k;
            end
        end
        sq  = t_acc'(best_dist) * t_acc'(best_dist);
        sum = (sse_acc > ACC_MAX - sq) ? ACC_MAX : sse_acc + sq;
        word.quantized   = level_set[best];
        word.level_index = t_lvl_idx'(best);
        word.error_sum   = sum;
        word.image_done  = last;
        sse_acc = last ? '0 : sum;
        return word;
    endfunction

    function automatic t_levels levels_for(t_level_style style);
        t_levels lv;
        t_pixel  a;
        t_pixel  b;
        a = t_pixel'($urandom_range(0, 255));
        b = t_pixel'($urandom_range(0, 255));
        for (int k = 0; k < NUM_REGS; k++) begin
            case (style)
                LV_SPREAD:    lv[k] = t_pixel'(k * 32 + $urandom_range(0, 31));
                LV_SCATTER:   lv[k] = t_pixel'($urandom_range(0, 255));
                LV_ALL_LOW:   lv[k] = 8'h00;
                LV_ALL_HIGH:  lv[k] = 8'hFF;
                LV_ALTERNATE: lv[k] = (k % 2 == 0) ? 8'hFF : 8'h00;
                default:      lv[k] = $urandom_range(0, 1) ? a : b;  // duplicated levels
            endcase
        end
        return lv;
    endfunction

    // Mostly uniform pixels, with extremes, values close to a level and
    // midpoints between two levels (rounded down, ties when the sum is even) mixed in.
    function automatic t_pixel pick_pixel(t_levels lv);
        int sel;
        int a;
        int b;
        sel = $urandom_range(0, 9);
        a   = $urandom_range(0, LEVELS - 1);
        b   = $urandom_range(0, LEVELS - 1);
        case (sel)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return t_pixel'(int'(lv[a]) + int'($urandom_range(0, 6)) - 3);
            3:       return t_pixel'((int'(lv[a]) + int'(lv[b])) / 2);
            default: return t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int next_image_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 1;
        if (sel == 1)
            return $urandom_range(100, 300);
        return $urandom_range(2, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Leaves valid high on return so that a back-to-back word follows without
    // a bubble; callers lower it for a gap.
    task automatic send_pixel(t_row row);
        offered_rows = {offered_rows, row};
        pix_bus.valid      <= 1'b1;
        pix_bus.pixel      <= row.pixel;
        pix_bus.last_pixel <= row.last;
        do @(posedge i_clk); while (!pix_bus.ready);
        words_sent++;
    endtask

    task automatic write_reg(t_cfg_idx index, t_pixel data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic load_levels(t_levels lv);
        for (int k = 0; k < NUM_REGS; k++)
            write_reg(REG_LEVEL_0 + t_cfg_idx'(k), lv[k]);
        cfg_bus.valid <= 1'b0;
    endtask

    // Writes past the level list must leave every level alone.
    task automatic write_stray(t_pixel data);
        write_reg(REG_BEYOND, data);
        write_reg(REG_TOP, data);
        cfg_bus.valid <= 1'b0;
    endtask

    // Stop offering pixels and wait until every accepted one has its result.
    task automatic wait_for_drain();
        pix_bus.valid <= 1'b0;
        while (words_checked != words_sent)
            @(posedge i_clk);
    endtask

    // Predictor, result check and watchdog share one block, so a pixel
    // accepted at an edge is always queued before any result of that edge.
    always @(posedge i_clk) begin
        t_row        row;
        t_qse_word   word;
        t_qse_word   want;
        int unsigned quiet_cycles;
        if (!i_rst_n) begin
            level_set    = LEVEL_RESET;
            sse_acc      = '0;
            quiet_cycles = 0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready && cfg_bus.index <= REG_LEVEL_LAST)
                level_set[cfg_bus.index[LVL_IDX_W-1:0]] = cfg_bus.data;

            if (pix_bus.valid && pix_bus.ready) begin
                row  = offered_rows.pop_front();
                word = quantize_pixel(pix_bus.pixel, pix_bus.last_pixel);
                if (row.typed) begin
                    word.quantized   = row.quantized;
                    word.level_index = row.level_index;
                    word.error_sum   = row.error_sum;
                    word.image_done  = row.last;
                end
                predicted_words = {predicted_words, word};
            end

            if (res_bus.valid && res_bus.ready) begin
                if (predicted_words.size() == 0) begin
                    report_mismatch("unexpected result word", res_bus.error_sum, '0);
                end else begin
                    want = predicted_words.pop_front();
                    words_checked++;
                    if (res_bus.quantized !== want.quantized)
                        report_mismatch("quantized", res_bus.quantized, want.quantized);
                    if (res_bus.level_index !== want.level_index)
                        report_mismatch("level_index", res_bus.level_index,
                                        want.level_index);
                    if (res_bus.error_sum !== want.error_sum)
                        report_mismatch("error_sum", res_bus.error_sum, want.error_sum);
                    if (res_bus.image_done !== want.image_done)
                        report_mismatch("image_done", res_bus.image_done, want.image_done);
                end
            end

            if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("quantization_squared_error_core test failed");
                $finish;
            end
        end
    end

    // Result side: stall patterns that change after each random span, plus
    // one long hold-off on request so the pipeline backs up into i_pix.
    initial begin
        t_stall_mode mode;
        int          span;
        int          period;
        int          duty;
        logic        rdy;
        forever begin
            mode   = t_stall_mode'($urandom_range(0, 3));
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 12);
            duty   = $urandom_range(1, period - 1);
            for (int c = 0; c < span; c++) begin
                if (hold_request) begin
                    res_bus.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    RX_OPEN:        rdy = 1'b1;
                    RX_RANDOM:      rdy = ($urandom_range(0, 9) < 7);
                    RX_EVERY_THIRD: rdy = (c % 3 != 2);
                    default:        rdy = (c % period < duty);
                endcase
                res_bus.ready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    // Pixel and configuration side.
    initial begin
        t_row    row;
        t_levels lv;
        int      sent;
        int      burst;
        int      gap;
        bit      gapless;
        i_rst_n            <= 1'b0;
        pix_bus.valid      <= 1'b0;
        pix_bus.pixel      <= '0;
        pix_bus.last_pixel <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= '0;
        cfg_bus.data       <= '0;
        words_sent     = 0;
        words_checked  = 0;
        mismatch_count = 0;
        hold_request   = 1'b0;
        image_left     = next_image_len();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Level writes only with the pipeline empty.
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            case (directed_rows[r].kind)
                ROW_LEVELS: begin
                    wait_for_drain();
                    load_levels(directed_rows[r].levels);
                end
                ROW_STRAY: begin
                    wait_for_drain();
                    write_stray(directed_rows[r].pixel);
                end
                default: send_pixel(directed_rows[r]);
            endcase
        end

        // Random phases: new levels each time, images that may run across
        // phases, bursts with random gaps. The hold phase offers pixels back
        // to back while the result side is held off.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_drain();
            lv = levels_for(phase_style[phase]);
            load_levels(lv);
            if ($urandom_range(0, 2) == 0)
                write_stray(t_pixel'($urandom_range(0, 255)));
            gapless = (phase == HOLD_PHASE);
            if (gapless)
                hold_request = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 24);
                for (int n = 0; n < burst && sent < ITEMS_PER_PHASE; n++) begin
                    row       = '0;
                    row.kind  = ROW_PIXEL;
                    row.pixel = pick_pixel(lv);
                    row.last  = (image_left == 1);
                    send_pixel(row);
                    image_left = row.last ? next_image_len() : image_left - 1;
                    sent++;
                end
                gap = gapless ? 0 : $urandom_range(0, 6);
                if (gap != 0) begin
                    pix_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (predicted_words.size() != 0)
            report_mismatch("results never delivered", predicted_words.size(), 0);
        if (mismatch_count == 0)
            $display("quantization_squared_error_core test passed");
        else
            $display("quantization_squared_error_core test failed");
        $finish;
    end

endmodule
